// ----- hdl/lrss_pkg.sv -----
`timescale 1ns / 1ps

package lrss_pkg;

  localparam int unsigned COUNT_W = 32;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned SCOUNT_W = 5;
  localparam int unsigned IN_DATA_W = 72;
  localparam int unsigned OUT_DATA_W = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    KIND_SELECT  = 2'd0,
    KIND_RECORD  = 2'd1,
    KIND_REPORT  = 2'd2,
    KIND_OFFLINE = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_REC   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  typedef struct packed {
    logic [COUNT_W-1:0] err;
    logic [COUNT_W-1:0] req;
  } counts_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

endpackage

// ----- hdl/least_requests_server_selector.sv -----
`timescale 1ns / 1ps

// Least-requests server selector. Each server keeps an online flag and
// saturating request and error counts. A select transaction walks the
// servers in use one entry per cycle through the single read port of the
// count memory and returns the online server with the fewest requests (ties
// go to fewer errors, then to the lower index), or index zero with the
// none-online flag in tuser. A select scans the first min(server_count,
// MAX_SERVERS, 16) entries, drains the last compare and then offers its
// result (straight away when no server is in use); a record response reads
// the entry, then does the saturating increment and write back; a health
// report or mark offline is written as it is accepted. The block takes one
// transaction at a time and accepts the next once the result has been taken.
module least_requests_server_selector #(
  parameter int unsigned MAX_SERVERS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lrss_pkg::SCOUNT_W-1:0]      cfg_data,    // server_count
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // server_index[3:0], response_ok[4], reported_errors[36:5],
  // reported_entries[68:37], reported_online[69], zero[71:70]
  input  logic [lrss_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [1:0]                         s_tuser,     // kind
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [lrss_pkg::OUT_DATA_W-1:0]    m_tdata,     // chosen_index[3:0], zero[7:4]
  output logic [0:0]                         m_tuser      // none_online
);

  import lrss_pkg::*;

  localparam int unsigned DEPTH = (MAX_SERVERS < 16) ? MAX_SERVERS : 16;
  localparam int unsigned IW = $clog2(DEPTH);
  localparam logic [SCOUNT_W-1:0] DEPTH_W = SCOUNT_W'(DEPTH);

  state_t state;
  logic [SCOUNT_W-1:0] server_count;
  logic [DEPTH-1:0] online;
  logic [DEPTH-1:0] vld;
  counts_t mem [DEPTH];

  counts_t rd_data;
  logic rd_vld;
  logic rd_online;
  logic [IW-1:0] rd_addr;

  logic wr_en;
  logic [IW-1:0] wr_addr;
  counts_t wr_data;

  logic [IW-1:0] ptr;
  logic pend;
  logic [IW-1:0] pend_idx;
  logic found;
  logic [IW-1:0] best_idx;
  counts_t best;
  logic [IW-1:0] op_idx;
  logic op_ok;

  kind_t kind;
  logic [INDEX_W-1:0] in_idx;
  logic in_ok;
  logic [COUNT_W-1:0] in_err;
  logic [COUNT_W-1:0] in_ent;
  logic in_online;
  logic idx_ok;
  logic accept;
  logic [SCOUNT_W-1:0] lim;
  counts_t cur;
  logic better;

  assign kind      = kind_t'(s_tuser);
  assign in_idx    = s_tdata[3:0];
  assign in_ok     = s_tdata[4];
  assign in_err    = s_tdata[36:5];
  assign in_ent    = s_tdata[68:37];
  assign in_online = s_tdata[69];
  assign idx_ok    = {1'b0, in_idx} < DEPTH_W;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign lim       = (server_count > DEPTH_W) ? DEPTH_W : server_count;

  assign cur = rd_vld ? rd_data : counts_t'('0);
  assign better = pend && rd_online &&
                  (!found || (cur.req < best.req) ||
                   ((cur.req == best.req) && (cur.err < best.err)));

  assign rd_addr = (state == S_SCAN) ? ptr : in_idx[IW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = op_idx;
    wr_data = '0;
    if (state == S_REC) begin
      wr_en       = 1'b1;
      wr_data.req = sat_inc(cur.req);
      wr_data.err = op_ok ? cur.err : sat_inc(cur.err);
    end else if (accept && (kind == KIND_REPORT) && idx_ok) begin
      wr_en       = 1'b1;
      wr_addr     = in_idx[IW-1:0];
      wr_data.req = in_ent;
      wr_data.err = in_err;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data   <= mem[rd_addr];
    rd_vld    <= vld[rd_addr];
    rd_online <= online[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      server_count <= SCOUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      server_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      online <= '1;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (accept && idx_ok) begin
        if (kind == KIND_REPORT) begin
          online[in_idx[IW-1:0]] <= in_online;
        end else if (kind == KIND_OFFLINE) begin
          online[in_idx[IW-1:0]] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ptr   <= '0;
      pend  <= 1'b0;
      found <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (kind)
              KIND_SELECT: begin
                found <= 1'b0;
                ptr   <= '0;
                state <= (lim == '0) ? S_OUT : S_SCAN;
              end
              KIND_RECORD: begin
                if (idx_ok) begin
                  state <= S_REC;
                end
              end
              KIND_REPORT, KIND_OFFLINE: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_REC: begin
          state <= S_IDLE;
        end
        S_SCAN: begin
          pend <= 1'b1;
          if (SCOUNT_W'(ptr) == lim - SCOUNT_W'(1)) begin
            state <= S_DRAIN;
          end else begin
            ptr <= ptr + IW'(1);
          end
        end
        S_DRAIN: begin
          pend  <= 1'b0;
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (better) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      pend_idx <= ptr;
    end
    if (accept) begin
      op_idx <= in_idx[IW-1:0];
      op_ok  <= in_ok;
    end
    if (better) begin
      best_idx <= pend_idx;
      best     <= cur;
    end
  end

  assign m_tvalid   = (state == S_OUT);
  assign m_tdata    = found ? OUT_DATA_W'(best_idx) : '0;
  assign m_tuser[0] = !found;

  a_pend_in_scan: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_SCAN || state == S_DRAIN))
    else $error("compare pending outside a scan");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("non-zero index with no server online");

  a_out_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_DRAIN || $past(state) == S_IDLE))
    else $error("result raised from an unexpected state");

  a_rec_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_REC) |=> (state == S_IDLE && vld[$past(op_idx)]))
    else $error("record did not write back its entry");

endmodule

// ----- tb/tb_least_requests_server_selector.sv -----
`timescale 1ns / 1ps

module tb_least_requests_server_selector;
  import lrss_pkg::*;

  localparam int SERVER_SLOTS = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 80;

  typedef struct {
    kind_t       kind;
    logic [3:0]  server;
    logic        ok;
    logic [31:0] rep_err;
    logic [31:0] rep_ent;
    logic        rep_on;
  } request_t;

  typedef struct {
    logic [3:0] index;
    logic       none;
  } pick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SCOUNT_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0] m_tuser;

  request_t pending_requests[$];
  request_t offered;
  pick_t expected_picks[$];

  logic [4:0]  servers_in_use;
  logic        online_tbl[SERVER_SLOTS];
  logic [31:0] req_tbl[SERVER_SLOTS];
  logic [31:0] err_tbl[SERVER_SLOTS];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic pressure_on = 1'b0;
  int hold_count = 0;
  int cycle_count = 0;
  int mismatches = 0;

  least_requests_server_selector #(
    .MAX_SERVERS(SERVER_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #6 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compute_pick(input request_t r);
    pick_t p;
    int lim;
    int best;
    bit found;
    if (r.kind == KIND_SELECT) begin
      lim = (servers_in_use > SERVER_SLOTS) ? SERVER_SLOTS : int'(servers_in_use);
      if (lim > 16) lim = 16;
      found = 1'b0;
      best = 0;
      for (int i = 0; i < lim; i++) begin
        if (online_tbl[i] && (!found || req_tbl[i] < req_tbl[best] ||
            (req_tbl[i] == req_tbl[best] && err_tbl[i] < err_tbl[best]))) begin
          best = i;
          found = 1'b1;
        end
      end
      p.index = found ? 4'(best) : 4'd0;
      p.none = !found;
      expected_picks.push_back(p);
    end else if (r.server < SERVER_SLOTS) begin
      case (r.kind)
        KIND_RECORD: begin
          if (req_tbl[r.server] != '1) req_tbl[r.server] = req_tbl[r.server] + 1;
          if (!r.ok && err_tbl[r.server] != '1) err_tbl[r.server] = err_tbl[r.server] + 1;
        end
        KIND_REPORT: begin
          err_tbl[r.server] = r.rep_err;
          req_tbl[r.server] = r.rep_ent;
          online_tbl[r.server] = r.rep_on;
        end
        default: online_tbl[r.server] = 1'b0;
      endcase
    end
  endtask

  function automatic request_t make_request(kind_t k, logic [3:0] s, logic ok,
                                            logic [31:0] e, logic [31:0] n, logic on);
    request_t r;
    r.kind = k;
    r.server = s;
    r.ok = ok;
    r.rep_err = e;
    r.rep_ent = n;
    r.rep_on = on;
    return r;
  endfunction

  function automatic logic [31:0] random_count();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 32'($urandom_range(3));
    if (roll < 80) return 32'hFFFF_FFFF - 32'($urandom_range(2));
    return $urandom;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int roll;
    roll = $urandom_range(99);
    if (roll < 35) r.kind = KIND_SELECT;
    else if (roll < 65) r.kind = KIND_RECORD;
    else if (roll < 85) r.kind = KIND_REPORT;
    else r.kind = KIND_OFFLINE;
    r.server = 4'($urandom_range(15));
    r.ok = 1'($urandom_range(1));
    r.rep_err = random_count();
    r.rep_ent = random_count();
    r.rep_on = ($urandom_range(99) < 75);
    return r;
  endfunction

  task automatic wait_until_drained();
    do @(posedge clk);
    while (pending_requests.size() != 0 || s_tvalid || expected_picks.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_server_count(input logic [4:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    servers_in_use = v;
  endtask

  // sender: hold the offered transaction until taken, then predict and advance
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        compute_pick(offered);
        void'(pending_requests.pop_front());
      end
      if (!(s_tvalid && !s_tready)) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_requests[0];
          s_tvalid <= 1'b1;
          s_tuser <= offered.kind;
          s_tdata <= {2'b00, offered.rep_on, offered.rep_ent, offered.rep_err,
                      offered.ok, offered.server};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!pressure_on) hold_count <= 0;
    else if (hold_count < HOLD_CYCLES) hold_count <= hold_count + 1;
  end

  always @(posedge clk) begin : result_monitor
    pick_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_picks.size() == 0) begin
          flag_mismatch($sformatf("unexpected result index %0d none %0d",
                                  m_tdata[3:0], m_tuser[0]));
        end else begin
          want = expected_picks.pop_front();
          if (m_tdata[3:0] !== want.index)
            flag_mismatch($sformatf("chosen_index %0d, want %0d", m_tdata[3:0], want.index));
          if (m_tuser[0] !== want.none)
            flag_mismatch($sformatf("none_online %0d, want %0d", m_tuser[0], want.none));
        end
      end
      m_tready <= !(pressure_on && hold_count < HOLD_CYCLES) &&
                  ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int counts[5];
    int idle_pcts[5];
    int stall_pcts[5];
    counts = '{16, $urandom_range(2, 15), 31, 1, $urandom_range(0, 31)};
    idle_pcts = '{0, 80, 0, 22, 0};
    stall_pcts = '{0, 0, 80, 22, 0};
    servers_in_use = 5'd1;
    for (int i = 0; i < SERVER_SLOTS; i++) begin
      online_tbl[i] = 1'b1;
      req_tbl[i] = '0;
      err_tbl[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // single server in use: none online, saturating request count
    pending_requests.push_back(make_request(KIND_SELECT, 4'd0, 1'b0, '0, '0, 1'b0));
    pending_requests.push_back(make_request(KIND_OFFLINE, 4'd0, 1'b0, '0, '0, 1'b0));
    pending_requests.push_back(make_request(KIND_SELECT, 4'd0, 1'b0, '0, '0, 1'b0));
    pending_requests.push_back(make_request(KIND_REPORT, 4'd0, 1'b1, 32'd5, '1, 1'b1));
    pending_requests.push_back(make_request(KIND_RECORD, 4'd0, 1'b0, '0, '0, 1'b0));
    pending_requests.push_back(make_request(KIND_SELECT, 4'd15, 1'b1, '1, '1, 1'b1));
    wait_until_drained();
    write_server_count(5'd16);

    // ties on requests broken by errors, then index; counts loaded while offline
    pending_requests.push_back(make_request(KIND_REPORT, 4'd1, 1'b0, 32'd1, '0, 1'b1));
    pending_requests.push_back(make_request(KIND_SELECT, 4'd0, 1'b0, '0, '0, 1'b0));
    pending_requests.push_back(make_request(KIND_RECORD, 4'd2, 1'b1, '0, '0, 1'b0));
    pending_requests.push_back(make_request(KIND_SELECT, 4'd0, 1'b0, '0, '0, 1'b0));
    pending_requests.push_back(make_request(KIND_REPORT, 4'd15, 1'b1, '1, '1, 1'b0));
    pending_requests.push_back(make_request(KIND_RECORD, 4'd15, 1'b0, '0, '0, 1'b0));
    pending_requests.push_back(make_request(KIND_SELECT, 4'd0, 1'b0, '0, '0, 1'b0));
    pending_requests.push_back(make_request(KIND_REPORT, 4'd15, 1'b0, '0, '0, 1'b1));
    pending_requests.push_back(make_request(KIND_OFFLINE, 4'd3, 1'b0, '0, '0, 1'b0));
    pending_requests.push_back(make_request(KIND_SELECT, 4'd0, 1'b0, '0, '0, 1'b0));
    pending_requests.push_back(make_request(KIND_RECORD, 4'd4, 1'b0, '0, '0, 1'b0));
    pending_requests.push_back(make_request(KIND_RECORD, 4'd5, 1'b0, '0, '0, 1'b0));
    pending_requests.push_back(make_request(KIND_SELECT, 4'd0, 1'b0, '0, '0, 1'b0));
    wait_until_drained();
    write_server_count(5'd0);
    pending_requests.push_back(make_request(KIND_SELECT, 4'd0, 1'b0, '0, '0, 1'b0));
    wait_until_drained();
    write_server_count(5'd31);
    pending_requests.push_back(make_request(KIND_SELECT, 4'd0, 1'b0, '0, '0, 1'b0));
    wait_until_drained();

    for (int ph = 0; ph < 5; ph++) begin
      write_server_count(5'(counts[ph]));
      send_idle_pct <= idle_pcts[ph];
      recv_stall_pct <= stall_pcts[ph];
      pressure_on <= (ph == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) pending_requests.push_back(random_request());
      wait_until_drained();
      pressure_on <= 1'b0;
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
